// ===== sv/asmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the alarm set and match controller.
// No dependencies.
package asmc_pkg;

    // Event kinds carried in s_tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ENTER = 2'd1;
    localparam logic [1:0] OP_EXIT  = 2'd2;

    // Decoded key codes
    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_SET   = 3'd1;
    localparam logic [2:0] KEY_SHIFT = 3'd2;
    localparam logic [2:0] KEY_ADD   = 3'd3;
    localparam logic [2:0] KEY_SUB   = 3'd4;

    localparam int unsigned BLINK_PERIOD_MS = 300;
    localparam logic [14:0] BLINK_HALF_RESET  = 15'(BLINK_PERIOD_MS / 2);

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    localparam logic [4:0] ALARM_HOUR_RESET = 5'd1;

    localparam logic [15:0] BLINK_TIMER_MAX = 16'hFFFF;

    typedef struct packed {
        logic       start_ring;
        logic       blank_minute;
        logic       blank_hour;
        logic       selected_field;
        logic       setting_mode;
        logic [5:0] alarm_minute_out;
        logic [4:0] alarm_hour_out;
    } result_t;

endpackage

// ===== sv/alarm_set_and_match_controller.sv =====
`timescale 1ns / 1ps
// Alarm set and match controller: a registered state update per event beat.
// Depends on asmc_pkg.
//
// Latency: the result beat is valid the cycle after its input beat is taken.
// Throughput: one event per clock; the single next-state/result logic stage
// feeds the output register, which frees whenever it is empty or being drained.
// Reset (aresetn low, synchronous): alarm 01:00, running mode, hour selected,
// blink timer cleared and field shown, half period 150 ms, no result pending.
module alarm_set_and_match_controller
    import asmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Blink half-period register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,     // blink_half_period

    // Event stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] elapsed_ms, [12:10] key_code, [13] fg_view,
    // [14] clock_setting_active, [19:15] clock_hour, [25:20] clock_minute,
    // [31:26] zero
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,      // [1:0] operation

    // Result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] alarm_hour_out, [10:5] alarm_minute_out, [11] setting_mode,
    // [12] selected_field, [13] blank_hour, [14] blank_minute, [15] start_ring
    output logic [15:0] m_tdata
);

    // Unpack the input beat
    logic [1:0] operation;
    logic [9:0] elapsed_ms;
    logic [2:0] key_code;
    logic       fg_view;
    logic       clock_setting_active;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;

    assign operation            = s_tuser;
    assign elapsed_ms           = s_tdata[9:0];
    assign key_code             = s_tdata[12:10];
    assign fg_view              = s_tdata[13];
    assign clock_setting_active = s_tdata[14];
    assign clock_hour           = s_tdata[19:15];
    assign clock_minute         = s_tdata[25:20];

    // Controller state
    logic [14:0] blink_half_reg;
    logic [4:0]  alarm_hour_reg,  alarm_hour_next;
    logic [5:0]  alarm_minute_reg, alarm_minute_next;
    logic        mode_setting_reg, mode_setting_next;
    logic        item_select_reg, item_select_next;
    logic [15:0] blink_timer_reg, blink_timer_next;
    logic        blink_hidden_reg, blink_hidden_next;
    logic [5:0]  prev_minute_reg, prev_minute_next;

    // Output register
    logic        m_valid_reg;
    result_t     result_reg, result_next;

    logic in_beat;
    logic [16:0] timer_sum;
    logic [15:0] timer_sat;

    // Accept a new event whenever the output slot is empty or draining.
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign timer_sum = {1'b0, blink_timer_reg} + 17'(elapsed_ms);
    assign timer_sat = timer_sum[16] ? BLINK_TIMER_MAX : timer_sum[15:0];

    always_comb begin
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        mode_setting_next = mode_setting_reg;
        item_select_next  = item_select_reg;
        blink_timer_next  = blink_timer_reg;
        blink_hidden_next = blink_hidden_reg;
        prev_minute_next  = prev_minute_reg;
        result_next       = '0;

        unique case (operation)
            OP_ENTER: begin
                mode_setting_next = 1'b0;
            end
            OP_EXIT: begin
                mode_setting_next = 1'b0;
                item_select_next  = 1'b0;
                blink_timer_next  = '0;
                blink_hidden_next = 1'b0;
            end
            OP_TICK: begin
                if (!mode_setting_reg) begin
                    // Running: enter setting from foreground, check for a fresh match.
                    if (key_code == KEY_SET && fg_view) begin
                        mode_setting_next = 1'b1;
                    end
                    result_next.start_ring = !clock_setting_active
                        && alarm_hour_reg == clock_hour
                        && alarm_minute_reg == clock_minute
                        && prev_minute_reg != alarm_minute_reg;
                end else if (fg_view) begin
                    // Advance the blink timer; toggle visibility at the half period.
                    blink_timer_next = timer_sat;
                    if (timer_sat >= {1'b0, blink_half_reg}) begin
                        blink_hidden_next = !blink_hidden_reg;
                        blink_timer_next  = '0;
                    end
                    case (key_code)
                        KEY_SET: begin
                            mode_setting_next = 1'b0;
                            item_select_next  = 1'b0;
                            blink_timer_next  = '0;
                            blink_hidden_next = 1'b0;
                        end
                        KEY_SHIFT: begin
                            item_select_next = !item_select_reg;
                        end
                        KEY_ADD, KEY_SUB: begin
                            // Step the selected field with wrap; show it again.
                            if (!item_select_reg) begin
                                if (key_code == KEY_ADD) begin
                                    alarm_hour_next = (alarm_hour_reg == HOUR_MAX)
                                        ? 5'd0 : alarm_hour_reg + 5'd1;
                                end else begin
                                    alarm_hour_next = (alarm_hour_reg == 5'd0)
                                        ? HOUR_MAX : alarm_hour_reg - 5'd1;
                                end
                            end else begin
                                if (key_code == KEY_ADD) begin
                                    alarm_minute_next = (alarm_minute_reg == MINUTE_MAX)
                                        ? 6'd0 : alarm_minute_reg + 6'd1;
                                end else begin
                                    alarm_minute_next = (alarm_minute_reg == 6'd0)
                                        ? MINUTE_MAX : alarm_minute_reg - 6'd1;
                                end
                            end
                            blink_hidden_next = 1'b0;
                            blink_timer_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                    result_next.blank_hour   = blink_hidden_next && !item_select_next;
                    result_next.blank_minute = blink_hidden_next && item_select_next;
                end
                prev_minute_next = clock_minute;
            end
            default: begin
                // Unused event kind: hold all state.
            end
        endcase

        result_next.alarm_hour_out   = alarm_hour_next;
        result_next.alarm_minute_out = alarm_minute_next;
        result_next.setting_mode     = mode_setting_next;
        result_next.selected_field   = item_select_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_half_reg   <= BLINK_HALF_RESET;
            alarm_hour_reg   <= ALARM_HOUR_RESET;
            alarm_minute_reg <= '0;
            mode_setting_reg <= 1'b0;
            item_select_reg  <= 1'b0;
            blink_timer_reg  <= '0;
            blink_hidden_reg <= 1'b0;
            prev_minute_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                blink_half_reg <= cfg_data;
            end
            if (in_beat) begin
                alarm_hour_reg   <= alarm_hour_next;
                alarm_minute_reg <= alarm_minute_next;
                mode_setting_reg <= mode_setting_next;
                item_select_reg  <= item_select_next;
                blink_timer_reg  <= blink_timer_next;
                blink_hidden_reg <= blink_hidden_next;
                prev_minute_reg  <= prev_minute_next;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                // Drop the result once it has been taken.
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; load it with every accepted event.
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    // Alarm time stays within a day.
    a_alarm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_hour_reg <= HOUR_MAX && alarm_minute_reg <= MINUTE_MAX)
        else $error("alarm time out of range");

    // At most one field blanks, and only in setting mode.
    a_blank_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (result_reg.blank_hour || result_reg.blank_minute) |->
        result_reg.setting_mode && !(result_reg.blank_hour && result_reg.blank_minute))
        else $error("blank flags inconsistent with setting mode");

    // A ring is only raised from running mode.
    a_ring_running: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && result_next.start_ring |-> !mode_setting_reg)
        else $error("ring raised while in setting mode");

    // The blink timer is cleared once it reaches the half period, so it stays below 2^15.
    a_timer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !blink_timer_reg[15])
        else $error("blink timer overrun");

    // A taken event always yields a pending result next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> m_valid_reg)
        else $error("result lost after accepted event");

endmodule
